### hw/rtl/lbpw_pkg.sv
// lbpw_pkg: shared types, constants and small functions of the bit-plane pixel writer
// no dependencies; used by led_bitplane_pixel_writer

package lbpw_pkg;

  localparam int PLANES  = 3;
  localparam int COLOURS = 3;

  // quantization thresholds
  localparam logic [7:0] LEVEL1_MIN = 8'h99;
  localparam logic [7:0] LEVEL2_MIN = 8'hcc;
  localparam logic [7:0] LEVEL3_MIN = 8'hff;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WR_READ,
    ST_WR_MODIFY,
    ST_RD_READ,
    ST_RD_OUT
  } state_t;

  // colour order within one plane group of the store
  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_RED   = 2'd1,
    CH_GREEN = 2'd2
  } colour_t;

  localparam logic [1:0] LAST_PLANE = 2'(PLANES - 1);

  function automatic logic [1:0] quantize(input logic [7:0] v);
    logic [1:0] lvl;
    if (v < LEVEL1_MIN) lvl = 2'd0;
    else if (v < LEVEL2_MIN) lvl = 2'd1;
    else if (v < LEVEL3_MIN) lvl = 2'd2;
    else lvl = 2'd3;
    return lvl;
  endfunction

  // row wiring inside a group of eight rows
  function automatic logic [2:0] row_wiring(input logic [2:0] r);
    logic [2:0] w;
    case (r)
      3'd0: w = 3'd7;
      3'd1: w = 3'd6;
      3'd2: w = 3'd5;
      3'd3: w = 3'd4;
      3'd4: w = 3'd2;
      3'd5: w = 3'd3;
      3'd6: w = 3'd0;
      3'd7: w = 3'd1;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  // bit position of a column inside its column byte
  function automatic logic [2:0] bit_wiring(input logic [2:0] c);
    logic [2:0] b;
    case (c)
      3'd0: b = 3'd7;
      3'd1: b = 3'd6;
      3'd2: b = 3'd5;
      3'd3: b = 3'd4;
      3'd4: b = 3'd0;
      3'd5: b = 3'd1;
      3'd6: b = 3'd2;
      3'd7: b = 3'd3;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/led_bitplane_pixel_writer.sv
// led_bitplane_pixel_writer: bit-plane frame store of an rgb led matrix with pixel writes
// and byte reads; depends on lbpw_pkg

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------------
//  in_     | input     | in_valid / in_ready  | mode, pixel_x, pixel_y, rgb levels, address
//  out_    | output    | out_valid / out_ready| read_data (only for read items)
//
//  a write item goes from accept through the row remap and base address state, then
//  nine read-modify-write bytes, each a read state and a modify state, all through the
//  single port pair of the store; a pixel off the panel returns to idle after the remap
//  a read item passes a read state and an output state; the result sits in an output
//  register and only a read waiting on a full output register stalls the sequencer
//  after reset the store is zeroed in a pass over ROWS*(COLS/8)*9 bytes (288 by default),
//  one byte a cycle, with in_ready low

module led_bitplane_pixel_writer #(
  parameter int ROWS = 16,
  parameter int COLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [3:0] in_pixel_x,
  input  logic [3:0] in_pixel_y,
  input  logic [7:0] in_red_level,
  input  logic [7:0] in_green_level,
  input  logic [7:0] in_blue_level,
  input  logic [8:0] in_byte_address,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data
);

  localparam int COL_BYTES   = COLS / 8;
  localparam int STORE_BYTES = ROWS * COL_BYTES * lbpw_pkg::PLANES * lbpw_pkg::COLOURS;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = (AW > 9) ? AW + 1 : 10;

  // frame store: one write port, one registered read port
  logic [7:0]    mem [STORE_BYTES];
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [7:0]    rd_data_r;

  lbpw_pkg::state_t  state_r, state_nxt;
  lbpw_pkg::colour_t colour_r, colour_nxt;
  logic [1:0]        plane_r, plane_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;     // clear counter, rmw address or read address
  logic              oob_r, oob_nxt;       // read address beyond the store

  // write item payload
  logic [3:0]        x_r, x_nxt;
  logic [3:0]        y_r, y_nxt;
  logic [1:0]        red_lvl_r, red_lvl_nxt;
  logic [1:0]        green_lvl_r, green_lvl_nxt;
  logic [1:0]        blue_lvl_r, blue_lvl_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  // orientation and wiring remap of the latched pixel
  logic [7:0]        pre_row;
  logic [7:0]        row;
  logic              x_ok, row_ok, col_ok;
  logic [AW-1:0]     slot_idx;
  logic [AW-1:0]     base;
  logic [7:0]        mask;
  logic [1:0]        lvl;
  logic              bit_set;
  logic              load_out;

  always_comb begin
    x_ok     = ({4'd0, x_r} <= 8'(COLS - 1));
    pre_row  = 8'(COLS - 1) - {4'd0, x_r};
    row      = {pre_row[7:3], lbpw_pkg::row_wiring(pre_row[2:0])};
    row_ok   = (row < 8'(ROWS));
    col_ok   = !y_r[3] || (COL_BYTES > 1);
    // pixel slot index times nine bytes per slot
    slot_idx = AW'(row) * AW'(COL_BYTES) + AW'(y_r[3]);
    base     = {slot_idx[AW-4:0], 3'd0} + slot_idx;
    mask     = 8'd1 << lbpw_pkg::bit_wiring(y_r[2:0]);
  end

  // level of the channel being processed, thermometer coded across planes
  always_comb begin
    case (colour_r)
      lbpw_pkg::CH_BLUE:  lvl = blue_lvl_r;
      lbpw_pkg::CH_RED:   lvl = red_lvl_r;
      lbpw_pkg::CH_GREEN: lvl = green_lvl_r;
      default:            lvl = 2'd0;
    endcase
    bit_set = (lvl > plane_r);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    colour_nxt    = colour_r;
    plane_nxt     = plane_r;
    addr_nxt      = addr_r;
    oob_nxt       = oob_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    red_lvl_nxt   = red_lvl_r;
    green_lvl_nxt = green_lvl_r;
    blue_lvl_nxt  = blue_lvl_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = 8'd0;
    load_out      = 1'b0;

    case (state_r)
      lbpw_pkg::ST_CLEAR: begin
        // zero one byte a cycle
        mem_we   = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(STORE_BYTES - 1)) begin
          addr_nxt  = '0;
          state_nxt = lbpw_pkg::ST_IDLE;
        end
      end
      lbpw_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode) begin
            addr_nxt  = AW'(in_byte_address);
            oob_nxt   = (CW'(in_byte_address) >= CW'(STORE_BYTES));
            state_nxt = lbpw_pkg::ST_RD_READ;
          end else begin
            x_nxt         = in_pixel_x;
            y_nxt         = in_pixel_y;
            red_lvl_nxt   = lbpw_pkg::quantize(in_red_level);
            green_lvl_nxt = lbpw_pkg::quantize(in_green_level);
            blue_lvl_nxt  = lbpw_pkg::quantize(in_blue_level);
            state_nxt     = lbpw_pkg::ST_CALC;
          end
        end
      end
      lbpw_pkg::ST_CALC: begin
        // pixel off the panel leaves the store untouched
        if (x_ok && row_ok && col_ok) begin
          addr_nxt   = base;
          plane_nxt  = 2'd0;
          colour_nxt = lbpw_pkg::CH_BLUE;
          state_nxt  = lbpw_pkg::ST_WR_READ;
        end else begin
          state_nxt = lbpw_pkg::ST_IDLE;
        end
      end
      lbpw_pkg::ST_WR_READ: begin
        state_nxt = lbpw_pkg::ST_WR_MODIFY;
      end
      lbpw_pkg::ST_WR_MODIFY: begin
        mem_we    = 1'b1;
        mem_wdata = bit_set ? (rd_data_r | mask) : (rd_data_r & ~mask);
        // offsets plane*3+colour run through consecutive bytes
        addr_nxt  = addr_r + AW'(1);
        state_nxt = lbpw_pkg::ST_WR_READ;
        case (colour_r)
          lbpw_pkg::CH_BLUE:  colour_nxt = lbpw_pkg::CH_RED;
          lbpw_pkg::CH_RED:   colour_nxt = lbpw_pkg::CH_GREEN;
          lbpw_pkg::CH_GREEN: begin
            colour_nxt = lbpw_pkg::CH_BLUE;
            plane_nxt  = plane_r + 2'd1;
            if (plane_r == lbpw_pkg::LAST_PLANE) begin
              state_nxt = lbpw_pkg::ST_IDLE;
            end
          end
          default: colour_nxt = lbpw_pkg::CH_BLUE;
        endcase
      end
      lbpw_pkg::ST_RD_READ: begin
        state_nxt = lbpw_pkg::ST_RD_OUT;
      end
      lbpw_pkg::ST_RD_OUT: begin
        // wait for room in the output register
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = lbpw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lbpw_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = oob_r ? 8'd0 : rd_data_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbpw_pkg::ST_CLEAR;
      addr_r      <= '0;
      colour_r    <= lbpw_pkg::CH_BLUE;
      plane_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      colour_r    <= colour_nxt;
      plane_r     <= plane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oob_r       <= oob_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    red_lvl_r   <= red_lvl_nxt;
    green_lvl_r <= green_lvl_nxt;
    blue_lvl_r  <= blue_lvl_nxt;
    out_data_r  <= out_data_nxt;
  end

  // store write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    rd_data_r <= mem[addr_r];
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

### hw/rtl/lbpw_chk.sv
// lbpw_chk: port-level checks of the bit-plane pixel writer, bound to the top level
// depends on led_bitplane_pixel_writer ports only

module lbpw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("result dropped or changed while stalled");

  // every accepted item keeps the sequencer busy next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted on back-to-back cycles");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during store clearing");

  // a new result only comes out of the busy read sequence
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // a write item produces no result right after its accept
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode && !out_valid |=> !out_valid)
    else $error("write item produced a result");

endmodule

bind led_bitplane_pixel_writer lbpw_chk u_lbpw_chk (.*);

### tb/testbench.sv
// testbench for led_bitplane_pixel_writer: pixel writes and byte reads of the bit-plane store
// a directed table, then random items, with results checked against a predictor of the store
// depends on lbpw_pkg and led_bitplane_pixel_writer
`timescale 1ns / 100ps

module testbench;

  // geometry of the instance under test (default parameters)
  localparam int ROWS_TB     = 16;
  localparam int COLS_TB     = 16;
  localparam int COL_BYTES   = COLS_TB / 8;
  localparam int STORE_BYTES = ROWS_TB * COL_BYTES * lbpw_pkg::PLANES * lbpw_pkg::COLOURS;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_ITEMS   = 150;   // tail of the run with no idling on either side
  localparam int STALL_LIMIT  = 4000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 40;    // margin for a trailing write to finish after its accept
  localparam int MAX_REPORTS  = 40;

  // wiring of rows inside a group of eight, and of columns inside a column byte
  localparam logic [2:0] ROW_MAP [8] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd2, 3'd3, 3'd0, 3'd1};
  localparam logic [2:0] BIT_MAP [8] = '{3'd7, 3'd6, 3'd5, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3};

  typedef struct {
    logic       mode;
    logic [3:0] px;
    logic [3:0] py;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] addr;
    bit         fixed;      // expected byte typed into the table
    logic [7:0] fixed_byte;
  } pixel_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_mode = MODE_WRITE;
  logic [3:0] in_pixel_x = '0;
  logic [3:0] in_pixel_y = '0;
  logic [7:0] in_red_level = '0;
  logic [7:0] in_green_level = '0;
  logic [7:0] in_blue_level = '0;
  logic [8:0] in_byte_address = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;

  // predicted contents of the frame store, and read bytes still owed by the block
  logic [7:0] plane_bytes [STORE_BYTES];
  logic [7:0] read_byte_q [$];

  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  bit  calm_phase = 1'b0;
  pixel_cmd_t directed_q [$];

  always #4 clk = ~clk;

  led_bitplane_pixel_writer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_red_level    (in_red_level),
    .in_green_level  (in_green_level),
    .in_blue_level   (in_blue_level),
    .in_byte_address (in_byte_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data)
  );

  // number of thresholds the channel reaches gives its brightness level
  function automatic logic [1:0] channel_level(input logic [7:0] v);
    logic [1:0] n;
    n = 2'd0;
    if (v >= lbpw_pkg::LEVEL1_MIN) n = n + 2'd1;
    if (v >= lbpw_pkg::LEVEL2_MIN) n = n + 2'd1;
    if (v >= lbpw_pkg::LEVEL3_MIN) n = n + 2'd1;
    return n;
  endfunction

  // thermometer code: plane p carries the pixel bit when the level is above p
  function automatic void fill_planes(input int base, input lbpw_pkg::colour_t ch,
                                      input logic [7:0] mask, input logic [1:0] lvl);
    int idx;
    for (int p = 0; p < lbpw_pkg::PLANES; p++) begin
      idx = base + p * lbpw_pkg::COLOURS + int'(ch);
      if (idx < STORE_BYTES) begin
        if (lvl > p) plane_bytes[idx] = plane_bytes[idx] | mask;
        else plane_bytes[idx] = plane_bytes[idx] & ~mask;
      end
    end
  endfunction

  // image column becomes the stored row (mirrored), image row the stored column
  function automatic void paint_pixel(input pixel_cmd_t c);
    int pre_row;
    int row;
    int col;
    int base;
    logic [7:0] mask;
    pre_row = COLS_TB - 1 - int'(c.px);
    col = int'(c.py);
    if (pre_row < 0) return;
    row = int'(ROW_MAP[pre_row % 8]) + (pre_row / 8) * 8;
    if (row >= ROWS_TB || col / 8 >= COL_BYTES) return;
    mask = 8'h01 << BIT_MAP[col % 8];
    base = (row * COL_BYTES + col / 8) * lbpw_pkg::PLANES * lbpw_pkg::COLOURS;
    fill_planes(base, lbpw_pkg::CH_RED, mask, channel_level(c.red));
    fill_planes(base, lbpw_pkg::CH_GREEN, mask, channel_level(c.green));
    fill_planes(base, lbpw_pkg::CH_BLUE, mask, channel_level(c.blue));
  endfunction

  function automatic pixel_cmd_t write_cmd(input int x, input int y, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
    pixel_cmd_t c;
    c.mode = MODE_WRITE;
    c.px = 4'(x);
    c.py = 4'(y);
    c.red = r;
    c.green = g;
    c.blue = b;
    c.addr = 9'($urandom);
    c.fixed = 1'b0;
    c.fixed_byte = '0;
    return c;
  endfunction

  function automatic pixel_cmd_t read_cmd(input int a, input bit fixed, input logic [7:0] val);
    pixel_cmd_t c;
    c.mode = MODE_READ;
    c.px = 4'($urandom);
    c.py = 4'($urandom);
    c.red = 8'($urandom);
    c.green = 8'($urandom);
    c.blue = 8'($urandom);
    c.addr = 9'(a);
    c.fixed = fixed;
    c.fixed_byte = val;
    return c;
  endfunction

  // channel values cluster on the quantization thresholds
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return lbpw_pkg::LEVEL1_MIN - 8'd1;
      1: return lbpw_pkg::LEVEL1_MIN;
      2: return lbpw_pkg::LEVEL2_MIN - 8'd1;
      3: return lbpw_pkg::LEVEL2_MIN;
      4: return lbpw_pkg::LEVEL3_MIN - 8'd1;
      5: return lbpw_pkg::LEVEL3_MIN;
      default: return 8'($urandom);
    endcase
  endfunction

  // drive one item at the falling edge, maybe after an idle burst, and hold it until taken
  task automatic send_cmd(input pixel_cmd_t c);
    int gap;
    gap = (!calm_phase && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= c.mode;
    in_pixel_x      <= c.px;
    in_pixel_y      <= c.py;
    in_red_level    <= c.red;
    in_green_level  <= c.green;
    in_blue_level   <= c.blue;
    in_byte_address <= c.addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // item accepted at this edge: update the predicted store or owe a byte
    if (c.mode == MODE_WRITE) begin
      paint_pixel(c);
    end else if (c.fixed) begin
      read_byte_q.push_back(c.fixed_byte);
    end else begin
      read_byte_q.push_back((int'(c.addr) < STORE_BYTES) ? plane_bytes[c.addr] : 8'h00);
    end
  endtask

  // result side stalls in random bursts until the calm tail of the run
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0 && !calm_phase) begin
        out_ready <= 1'b0;
        stall = stall - 1;
      end else begin
        out_ready <= 1'b1;
        stall = 0;
        if (!calm_phase && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 5);
      end
    end
  end

  // compare each returned byte with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (read_byte_q.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: unexpected read_data expected none actual %02h",
                   $time, out_read_data);
      end else begin
        if (out_read_data !== read_byte_q[0]) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: read_data mismatch expected %02h actual %02h",
                     $time, read_byte_q[0], out_read_data);
        end
        void'(read_byte_q.pop_front());
      end
    end
  end

  // watchdog: the clearing pass after reset is the longest legal quiet stretch
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pixel_cmd_t c;
    for (int i = 0; i < STORE_BYTES; i++) plane_bytes[i] = 8'h00;

    // store is all zero after reset; addresses past the store read as zero
    directed_q.push_back(read_cmd(0, 1'b1, 8'h00));
    directed_q.push_back(read_cmd(STORE_BYTES - 1, 1'b1, 8'h00));
    directed_q.push_back(read_cmd(STORE_BYTES, 1'b1, 8'h00));
    directed_q.push_back(read_cmd(511, 1'b1, 8'h00));
    // full white in one corner, then its blue, red and green planes
    directed_q.push_back(write_cmd(0, 0, 8'hff, 8'hff, 8'hff));
    directed_q.push_back(read_cmd(162, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(166, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(170, 1'b0, 8'h00));
    // values one below and on the thresholds, opposite corner
    directed_q.push_back(write_cmd(15, 15, 8'h98, 8'h99, 8'hcb));
    directed_q.push_back(read_cmd(135, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(136, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(137, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(140, 1'b0, 8'h00));
    directed_q.push_back(write_cmd(0, 15, 8'hcc, 8'hfe, 8'h00));
    directed_q.push_back(read_cmd(172, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(175, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(179, 1'b0, 8'h00));
    // black over white clears all nine planes of the pixel
    directed_q.push_back(write_cmd(0, 0, 8'h00, 8'h00, 8'h00));
    directed_q.push_back(read_cmd(162, 1'b0, 8'h00));
    directed_q.push_back(read_cmd(300, 1'b1, 8'h00));
    // pixels across the row-group and column-byte boundaries
    directed_q.push_back(write_cmd(7, 8, 8'hff, 8'hcc, 8'h99));
    directed_q.push_back(write_cmd(8, 7, 8'h99, 8'hcc, 8'hff));
    directed_q.push_back(read_cmd(285, 1'b0, 8'h00));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) send_cmd(directed_q[i]);

    // random part: half writes, half reads, a few reads past the end of the store
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm_phase = 1'b1;
      if ($urandom_range(0, 1) == 0) begin
        c = write_cmd($urandom_range(0, 15), $urandom_range(0, 15),
                      pick_level(), pick_level(), pick_level());
      end else if ($urandom_range(0, 6) == 0) begin
        c = read_cmd($urandom_range(STORE_BYTES, 511), 1'b0, 8'h00);
      end else begin
        c = read_cmd($urandom_range(0, STORE_BYTES - 1), 1'b0, 8'h00);
      end
      send_cmd(c);
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // let owed bytes arrive, then give a trailing write time to finish
    while (read_byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && read_byte_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
